>>> sv/bidaf_pkg.sv
// Package for the bus id acceptance filter table.
// Holds command and status codes, payload structs and the token passed along the cell chain.
// No dependencies.
package bidaf_pkg;

    localparam int MASK_W  = 16;
    localparam int COUNT_W = 5;

    localparam logic [7:0] ID_WILDCARD   = 8'hFF;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] CMD_REG   = 2'd0;
    localparam logic [1:0] CMD_UNREG = 2'd1;
    localparam logic [1:0] CMD_FRAME = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] src_id;
        logic [7:0] dst_id;
        logic [3:0] owner;
        logic [1:0] device;
        logic [4:0] origin_owner;
        logic [7:0] frame_length;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] match_count;
        logic [MASK_W-1:0]  deliver_mask;
    } out_t;

    // Request travelling down the chain, one cell per cycle
    typedef struct packed {
        logic               vld;
        logic [1:0]         cmd;
        logic [7:0]         src_id;
        logic [7:0]         dst_id;
        logic [3:0]         owner;
        logic [1:0]         device;
        logic [4:0]         origin_owner;
        logic               drop;
        logic               done;
        logic [COUNT_W-1:0] count;
        logic [MASK_W-1:0]  mask;
    } tok_t;

endpackage

>>> sv/bus_id_acceptance_filter_table.sv
// Top level of the bus id acceptance filter table: request intake, cell chain, result buffer.
// Depends on bidaf_pkg and bidaf_cell.
//
//   channel   direction  ports                      payload
//   request   in         s_valid s_ready s_data     bidaf_pkg::in_t
//   result    out        m_valid m_ready m_data     bidaf_pkg::out_t
//
// A request walks the chain one slot per cycle, from the intake to the result buffer.
// One request is in the chain at a time; the next is taken once its result is registered,
// so no new request is accepted while one is still walking the chain.
// A result waiting on m_ready sits in the output register; one more can finish behind it
// in a spare slot, after which s_ready drops until the output drains.
// aresetn (synchronous) empties the table and the chain; no clearing pass is needed.
module bus_id_acceptance_filter_table #(
    parameter int ENTRIES      = 16,
    parameter int MAX_DATA_LEN = 253
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bidaf_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bidaf_pkg::out_t  m_data
);

    localparam int MAX_FRAME_LEN = MAX_DATA_LEN + 2;

    bidaf_pkg::tok_t tok [ENTRIES+1];
    logic [ENTRIES:0] chain_vld;

    logic            busy_reg, busy_next;
    logic            m_valid_reg, m_valid_next;
    logic            pend_reg, pend_next;
    bidaf_pkg::out_t m_data_reg, m_data_next;
    bidaf_pkg::out_t pend_data_reg, pend_data_next;
    bidaf_pkg::out_t res;

    logic accept, exit_req, drop;

    assign s_ready = !busy_reg && !pend_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        drop = s_data.frame_length < bidaf_pkg::MIN_FRAME_LEN
            || 32'(s_data.frame_length) > MAX_FRAME_LEN;
        tok[0].vld          = accept;
        tok[0].cmd          = s_data.cmd;
        tok[0].src_id       = s_data.src_id;
        tok[0].dst_id       = s_data.dst_id;
        tok[0].owner        = s_data.owner;
        tok[0].device       = s_data.device;
        tok[0].origin_owner = s_data.origin_owner;
        tok[0].drop         = drop;
        tok[0].done         = 1'b0;
        tok[0].count        = '0;
        tok[0].mask         = '0;
    end

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        bidaf_cell #(.IDX(k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok[k]),
            .tok_o   (tok[k+1])
        );
    end

    for (genvar k = 0; k <= ENTRIES; k++) begin : g_vld
        assign chain_vld[k] = tok[k].vld;
    end

    assign exit_req = tok[ENTRIES].vld;

    always_comb begin
        res.match_count  = tok[ENTRIES].count;
        res.deliver_mask = tok[ENTRIES].mask;
        unique case (tok[ENTRIES].cmd)
            bidaf_pkg::CMD_REG:
                res.status = tok[ENTRIES].done ? bidaf_pkg::ST_OK : bidaf_pkg::ST_FULL;
            bidaf_pkg::CMD_UNREG:
                res.status = tok[ENTRIES].done ? bidaf_pkg::ST_OK : bidaf_pkg::ST_NOT_FOUND;
            bidaf_pkg::CMD_FRAME:
                res.status = tok[ENTRIES].drop ? bidaf_pkg::ST_DROPPED : bidaf_pkg::ST_OK;
            default:
                res.status = bidaf_pkg::ST_OK;
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;

        if (accept) begin
            busy_next = 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            if (pend_reg) begin
                m_data_next = pend_data_reg;
                pend_next   = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (exit_req) begin
            busy_next = 1'b0;
            if (!m_valid_reg || m_ready) begin
                m_valid_next = 1'b1;
                m_data_next  = res;
            end else begin
                pend_next      = 1'b1;
                pend_data_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_vld))
        else $error("more than one request in the chain");

    a_exit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_req |-> busy_reg)
        else $error("request left the chain while not busy");

    a_spare_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> m_valid_reg && !busy_reg)
        else $error("spare result held with output empty or chain busy");

    a_cmd_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        exit_req && (tok[ENTRIES].cmd != bidaf_pkg::CMD_FRAME || tok[ENTRIES].drop)
        |-> tok[ENTRIES].count == '0 && tok[ENTRIES].mask == '0)
        else $error("non-frame or dropped request picked up matches");

endmodule

>>> sv/bidaf_cell.sv
// One filter table slot and its stage of the request chain.
// Depends on bidaf_pkg.
module bidaf_cell #(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  bidaf_pkg::tok_t  tok_i,
    output bidaf_pkg::tok_t  tok_o
);

    // beyond the reported mask width this shifts out to zero
    localparam logic [bidaf_pkg::MASK_W-1:0] OWN_BIT =
        bidaf_pkg::MASK_W'(1) << IDX;

    logic            valid_reg, valid_next;
    logic [7:0]      src_reg, dst_reg;
    logic [3:0]      owner_reg;
    logic [1:0]      scope_reg;
    bidaf_pkg::tok_t tok_reg, tok_next;

    logic do_reg, do_unreg, hit;

    always_comb begin
        do_reg = tok_i.vld && tok_i.cmd == bidaf_pkg::CMD_REG && !tok_i.done && !valid_reg;
        do_unreg = tok_i.vld && tok_i.cmd == bidaf_pkg::CMD_UNREG && !tok_i.done && valid_reg
            && src_reg == tok_i.src_id && dst_reg == tok_i.dst_id
            && owner_reg == tok_i.owner && scope_reg == tok_i.device;
        hit = tok_i.vld && tok_i.cmd == bidaf_pkg::CMD_FRAME && !tok_i.drop && valid_reg
            && (scope_reg == 2'd0 || scope_reg == tok_i.device)
            && (dst_reg == bidaf_pkg::ID_WILDCARD || dst_reg == tok_i.dst_id)
            && (src_reg == bidaf_pkg::ID_WILDCARD || src_reg == tok_i.src_id);

        valid_next = valid_reg;
        if (do_reg) begin
            valid_next = 1'b1;
        end else if (do_unreg) begin
            valid_next = 1'b0;
        end

        tok_next = tok_i;
        if (do_reg || do_unreg) begin
            tok_next.done = 1'b1;
        end
        if (hit) begin
            if (tok_i.count != bidaf_pkg::COUNT_MAX) begin
                tok_next.count = tok_i.count + 1'b1;
            end
            // own frames are counted, not delivered
            if ({1'b0, owner_reg} != tok_i.origin_owner) begin
                tok_next.mask = tok_i.mask | OWN_BIT;
            end
        end
    end

    // only the valid flag of the token is reset; the payload follows it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_reg) begin
            src_reg   <= tok_i.src_id;
            dst_reg   <= tok_i.dst_id;
            owner_reg <= tok_i.owner;
            scope_reg <= tok_i.device;
        end
    end

    assign tok_o = tok_reg;

endmodule

>>> dv/tb_bus_id_acceptance_filter_table.sv
// Self-checking testbench for bus_id_acceptance_filter_table: a directed table, then random
// register/unregister/frame/undefined traffic checked against a behavioral copy of the filter table.
// Depends on bidaf_pkg and the RTL of bus_id_acceptance_filter_table.
module tb_bus_id_acceptance_filter_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 16;
    localparam int MAX_DATA_LEN = 253;
    localparam int N_RANDOM     = 1950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int N_DIR        = 26;

    localparam logic [1:0] CMD_UNDEF = 2'd3;
    localparam bidaf_pkg::out_t NO_VERDICT = '0;

    typedef struct packed {
        bidaf_pkg::in_t  req;
        logic            typed;
        bidaf_pkg::out_t want;
    } dir_row_t;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    bidaf_pkg::in_t  s_data;
    logic            m_valid;
    logic            m_ready;
    bidaf_pkg::out_t m_data;

    // shadow copy of the filter table
    logic       tbl_valid [ENTRIES];
    logic [7:0] tbl_src   [ENTRIES];
    logic [7:0] tbl_dst   [ENTRIES];
    logic [3:0] tbl_owner [ENTRIES];
    logic [1:0] tbl_scope [ENTRIES];

    bidaf_pkg::out_t verdict_q [$];
    bidaf_pkg::out_t head;
    int              mismatches = 0;
    int              burst_left = 0;
    dir_row_t        dir_tab [N_DIR];

    bus_id_acceptance_filter_table #(
        .ENTRIES      (ENTRIES),
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %0s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic bidaf_pkg::out_t table_apply(input bidaf_pkg::in_t r);
        bidaf_pkg::out_t v;
        bit              done;
        v = '0;
        done = 1'b0;
        case (r.cmd)
            bidaf_pkg::CMD_REG: begin
                v.status = bidaf_pkg::ST_FULL;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && !tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_src[i]   = r.src_id;
                        tbl_dst[i]   = r.dst_id;
                        tbl_owner[i] = r.owner;
                        tbl_scope[i] = r.device;
                        v.status     = bidaf_pkg::ST_OK;
                        done         = 1'b1;
                    end
                end
            end
            bidaf_pkg::CMD_UNREG: begin
                v.status = bidaf_pkg::ST_NOT_FOUND;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && tbl_valid[i] && tbl_src[i] == r.src_id &&
                        tbl_dst[i] == r.dst_id && tbl_owner[i] == r.owner &&
                        tbl_scope[i] == r.device) begin
                        tbl_valid[i] = 1'b0;
                        v.status     = bidaf_pkg::ST_OK;
                        done         = 1'b1;
                    end
                end
            end
            bidaf_pkg::CMD_FRAME: begin
                if (r.frame_length < bidaf_pkg::MIN_FRAME_LEN ||
                    int'(r.frame_length) > MAX_DATA_LEN + 2) begin
                    v.status = bidaf_pkg::ST_DROPPED;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tbl_valid[i] &&
                            (tbl_scope[i] == 2'd0 || tbl_scope[i] == r.device) &&
                            (tbl_dst[i] == bidaf_pkg::ID_WILDCARD ||
                             tbl_dst[i] == r.dst_id) &&
                            (tbl_src[i] == bidaf_pkg::ID_WILDCARD ||
                             tbl_src[i] == r.src_id)) begin
                            if (v.match_count != bidaf_pkg::COUNT_MAX)
                                v.match_count = v.match_count + 1'b1;
                            // sender's own entries are counted, not delivered
                            if ({1'b0, tbl_owner[i]} != r.origin_owner &&
                                i < bidaf_pkg::MASK_W)
                                v.deliver_mask[i] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic bidaf_pkg::in_t mk_req(input logic [1:0] cmd, input logic [7:0] src,
                                              input logic [7:0] dst, input logic [3:0] own,
                                              input logic [1:0] dev, input logic [4:0] origin,
                                              input logic [7:0] flen);
        bidaf_pkg::in_t r;
        r.cmd          = cmd;
        r.src_id       = src;
        r.dst_id       = dst;
        r.owner        = own;
        r.device       = dev;
        r.origin_owner = origin;
        r.frame_length = flen;
        return r;
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 5))
            0: return bidaf_pkg::ID_WILDCARD;
            1: return 8'h00;
            2: return 8'h10;
            3: return 8'h20;
            default: return 8'($urandom);
        endcase
    endfunction

    // Index of a random live entry, or -1 when the table is empty.
    function automatic int pick_live();
        int n_live;
        int nth;
        n_live = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i]) n_live++;
        if (n_live == 0)
            return -1;
        nth = $urandom_range(0, n_live - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (nth == 0)
                    return i;
                nth--;
            end
        end
        return -1;
    endfunction

    function automatic bidaf_pkg::in_t gen_request(input bit filling);
        bidaf_pkg::in_t r;
        int             roll;
        int             live;
        int             pick;
        r = bidaf_pkg::in_t'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        live = pick_live();
        if (roll < 5) begin
            r.cmd = CMD_UNDEF;
        end else if (roll < (filling ? 50 : 20)) begin
            r.cmd    = bidaf_pkg::CMD_REG;
            r.src_id = pick_id();
            r.dst_id = pick_id();
        end else if (roll < 65) begin
            r.cmd = bidaf_pkg::CMD_UNREG;
            if (live >= 0 && $urandom_range(0, 4) != 0) begin
                r.src_id = tbl_src[live];
                r.dst_id = tbl_dst[live];
                r.owner  = tbl_owner[live];
                r.device = tbl_scope[live];
                // near miss now and then
                if ($urandom_range(0, 5) == 0)
                    r.owner = r.owner ^ 4'h1;
            end else begin
                r.src_id = pick_id();
                r.dst_id = pick_id();
            end
        end else begin
            r.cmd    = bidaf_pkg::CMD_FRAME;
            r.src_id = pick_id();
            r.dst_id = pick_id();
            if (live >= 0 && $urandom_range(0, 9) < 6) begin
                if (tbl_src[live] != bidaf_pkg::ID_WILDCARD) r.src_id = tbl_src[live];
                if (tbl_dst[live] != bidaf_pkg::ID_WILDCARD) r.dst_id = tbl_dst[live];
                if (tbl_scope[live] != 2'd0 && $urandom_range(0, 9) < 7)
                    r.device = tbl_scope[live];
            end
            pick = $urandom_range(0, 9);
            if (pick < 3 && live >= 0)
                r.origin_owner = {1'b0, tbl_owner[live]};
            else if (pick < 5)
                r.origin_owner = 5'd16;
            else
                r.origin_owner = 5'($urandom_range(0, 31));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                r.frame_length = 8'($urandom_range(0, 4));
            else if (pick == 1)
                r.frame_length = 8'($urandom_range(0, 255));
            else
                r.frame_length = 8'($urandom_range(5, 255));
        end
        return r;
    endfunction

    // Presents one request, waits for it to be taken, then records its expected result.
    task automatic send_request(input bidaf_pkg::in_t r, input logic typed,
                                input bidaf_pkg::out_t want);
        bidaf_pkg::out_t v;
        int              gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_data  <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        v = table_apply(r);
        verdict_q.push_back(typed ? want : v);
    endtask

    task automatic drain_pause();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_src[i]   = '0;
            tbl_dst[i]   = '0;
            tbl_owner[i] = '0;
            tbl_scope[i] = '0;
        end

        // empty table, the lower length limit, undefined command, then fill to full
        dir_tab[0]  = '{mk_req(bidaf_pkg::CMD_FRAME, 8'h00, 8'h00, 4'h0, 2'd0, 5'd16, 8'd5),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_OK, 5'd0, 16'h0}};
        dir_tab[1]  = '{mk_req(bidaf_pkg::CMD_FRAME, 8'h10, 8'h20, 4'h0, 2'd1, 5'd0, 8'd4),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_DROPPED, 5'd0, 16'h0}};
        dir_tab[2]  = '{mk_req(bidaf_pkg::CMD_FRAME, 8'hFF, 8'hFF, 4'hF, 2'd3, 5'd31, 8'd0),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_DROPPED, 5'd0, 16'h0}};
        dir_tab[3]  = '{mk_req(bidaf_pkg::CMD_UNREG, 8'hFF, 8'hFF, 4'hF, 2'd3, 5'd0, 8'd0),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_NOT_FOUND, 5'd0, 16'h0}};
        dir_tab[4]  = '{mk_req(CMD_UNDEF, 8'hFF, 8'hFF, 4'hF, 2'd3, 5'd31, 8'hFF),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_OK, 5'd0, 16'h0}};
        dir_tab[5]  = '{mk_req(bidaf_pkg::CMD_REG, 8'h10, 8'h20, 4'h1, 2'd0, 5'd0, 8'd0),
                        1'b0, NO_VERDICT};
        dir_tab[6]  = '{mk_req(bidaf_pkg::CMD_REG, 8'h10, 8'h20, 4'h1, 2'd0, 5'd31, 8'hFF),
                        1'b0, NO_VERDICT};
        dir_tab[7]  = '{mk_req(bidaf_pkg::CMD_REG, 8'hFF, 8'hFF, 4'h0, 2'd0, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[8]  = '{mk_req(bidaf_pkg::CMD_REG, 8'hFF, 8'h20, 4'h2, 2'd1, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[9]  = '{mk_req(bidaf_pkg::CMD_REG, 8'h10, 8'hFF, 4'h3, 2'd2, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[10] = '{mk_req(bidaf_pkg::CMD_REG, 8'h00, 8'h00, 4'hF, 2'd3, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[11] = '{mk_req(bidaf_pkg::CMD_REG, 8'hFF, 8'hFF, 4'hF, 2'd3, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[12] = '{mk_req(bidaf_pkg::CMD_REG, 8'h7F, 8'h80, 4'h4, 2'd1, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[13] = '{mk_req(bidaf_pkg::CMD_REG, 8'h80, 8'h7F, 4'h5, 2'd2, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[14] = '{mk_req(bidaf_pkg::CMD_REG, 8'h10, 8'h20, 4'h6, 2'd3, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[15] = '{mk_req(bidaf_pkg::CMD_REG, 8'hFF, 8'hFF, 4'h7, 2'd1, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[16] = '{mk_req(bidaf_pkg::CMD_REG, 8'h01, 8'hFE, 4'h8, 2'd0, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[17] = '{mk_req(bidaf_pkg::CMD_REG, 8'hFE, 8'h01, 4'h9, 2'd2, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[18] = '{mk_req(bidaf_pkg::CMD_REG, 8'hFF, 8'h00, 4'hA, 2'd0, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[19] = '{mk_req(bidaf_pkg::CMD_REG, 8'h00, 8'hFF, 4'hB, 2'd0, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[20] = '{mk_req(bidaf_pkg::CMD_REG, 8'h10, 8'h20, 4'hC, 2'd2, 5'd0, 8'd9),
                        1'b0, NO_VERDICT};
        dir_tab[21] = '{mk_req(bidaf_pkg::CMD_REG, 8'h55, 8'hAA, 4'h3, 2'd1, 5'd0, 8'd9),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_FULL, 5'd0, 16'h0}};
        // device 0 frame from owner 1 at max length; then a bus frame on device 3
        dir_tab[22] = '{mk_req(bidaf_pkg::CMD_FRAME, 8'h10, 8'h20, 4'h0, 2'd0, 5'd1, 8'hFF),
                        1'b0, NO_VERDICT};
        dir_tab[23] = '{mk_req(bidaf_pkg::CMD_FRAME, 8'h10, 8'h20, 4'h0, 2'd3, 5'd16, 8'd6),
                        1'b0, NO_VERDICT};
        dir_tab[24] = '{mk_req(bidaf_pkg::CMD_UNREG, 8'h10, 8'h20, 4'h1, 2'd0, 5'd0, 8'd0),
                        1'b0, NO_VERDICT};
        dir_tab[25] = '{mk_req(bidaf_pkg::CMD_UNREG, 8'h10, 8'h20, 4'h1, 2'd1, 5'd0, 8'd0),
                        1'b1, bidaf_pkg::out_t'{bidaf_pkg::ST_NOT_FOUND, 5'd0, 16'h0}};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].want);
        drain_pause();

        // alternate fill-heavy and drain-heavy stretches so occupancy sweeps empty to full
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 400 == 399)
                drain_pause();
            send_request(gen_request((n / 150) % 2 == 0), 1'b0, NO_VERDICT);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4 * ENTRIES) @(posedge aclk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (mismatches == 0)
            $display("bus_id_acceptance_filter_table regression: pass");
        else
            $display("bus_id_acceptance_filter_table regression: fail");
        $finish;
    end

    // receiver: rotating stall pattern, reshuffled now and then, with rare long stalls
    initial begin : receiver
        logic [15:0] pat;
        int          pat_age;
        int          hold;
        m_ready = 1'b0;
        pat     = '1;
        pat_age = 0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                if (pat_age == 0) begin
                    pat_age = $urandom_range(50, 300);
                    case ($urandom_range(0, 3))
                        0: pat = '1;
                        1: pat = 16'($urandom);
                        2: pat = 16'($urandom | $urandom);
                        default: pat = 16'($urandom & $urandom) | 16'h1;
                    endcase
                end
                pat_age--;
                pat = {pat[14:0], pat[15]};
                m_ready <= pat[0];
                if ($urandom_range(0, 499) == 0)
                    hold = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result with no request pending: %h", m_data));
            end else begin
                head = verdict_q.pop_front();
                if (m_data.status != head.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_data.status, head.status));
                if (m_data.match_count != head.match_count)
                    report_mismatch($sformatf("match_count got %0d want %0d",
                                              m_data.match_count, head.match_count));
                if (m_data.deliver_mask != head.deliver_mask)
                    report_mismatch($sformatf("deliver_mask got %h want %h",
                                              m_data.deliver_mask, head.deliver_mask));
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("TIMEOUT: no handshake for %0d cycles", IDLE_LIMIT);
        $display("bus_id_acceptance_filter_table regression: fail");
        $finish;
    end

endmodule

>>> sim.f
sv/bidaf_pkg.sv
sv/bidaf_cell.sv
sv/bus_id_acceptance_filter_table.sv
dv/tb_bus_id_acceptance_filter_table.sv
